// File: sv/integer_to_ascii_hex_decimal_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII converter
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_HEX_DECIMAL_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_HEX_DECIMAL_TOP_MACROS_SVH

`ifndef SYNTH
// Check that is switched off while reset is held.
`define I2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds while reset is held.
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2A_ASSERT(lbl, prop, msg)
`define I2A_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and character helpers of the integer to ASCII
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

  localparam int NUM_DIGITS = 10;
  localparam logic [3:0] LAST_DIGIT = 4'd9;

  typedef enum logic [1:0] {
    MODE_HEX_BYTE = 2'd0,
    MODE_HEX_WORD = 2'd1,
    MODE_UDEC     = 2'd2,
    MODE_SDEC     = 2'd3
  } mode_t;

  localparam logic [31:0] DEC_WEIGHT [NUM_DIGITS] = '{
    32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
    32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
  };

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

  // Conversion record handed from cell to cell.
  typedef struct packed {
    mode_t      mode;
    logic       neg;
    logic [31:0] num;
    logic [31:0] rem;
    digit_vec_t digits;
    logic       started;
    logic [3:0] start_idx;
  } conv_rec_t;

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] c;
    if (n <= 4'd9) begin
      c = CHAR_ZERO + 7'(n);
    end else begin
      c = CHAR_UPPER_A + 7'(n) - 7'd10;
    end
    return c;
  endfunction

  function automatic logic [6:0] dec_char(input logic [3:0] d);
    return CHAR_ZERO + 7'(d);
  endfunction

endpackage

`default_nettype wire

// File: sv/i2a_cell.sv
// ----------------------------------------------------------------------------
// i2a_cell
// One decimal digit cell: extracts the digit of its weight from the running
// remainder and hands the record on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         idx,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire i2a_pkg::conv_rec_t rec_in,
  output logic                    vld_out,
  output i2a_pkg::conv_rec_t      rec_out
);

  logic [31:0]        weight;
  logic [33:0]        thr [10];
  logic [33:0]        diff;
  logic [3:0]         dig;
  logic               hit;
  i2a_pkg::conv_rec_t rec_nxt;
  logic               vld_r;
  i2a_pkg::conv_rec_t rec_r;

  // The index is tied per cell, so the multiples below fold to constants.
  always_comb begin
    weight = i2a_pkg::DEC_WEIGHT[idx];
    thr[0] = 34'd0;
    for (int k = 1; k < 10; k++) begin
      thr[k] = 34'(weight) * 34'(k);
    end
    dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, rec_in.rem} >= thr[k]) begin
        dig = 4'(k);
      end
    end
    diff = {2'b00, rec_in.rem} - thr[dig];
    hit  = !rec_in.started && ((dig != 4'd0) || (idx == i2a_pkg::LAST_DIGIT));

    rec_nxt     = rec_in;
    rec_nxt.rem = diff[31:0];
    for (int j = 0; j < i2a_pkg::NUM_DIGITS; j++) begin
      if (4'(j) == idx) begin
        rec_nxt.digits[j] = dig;
      end
    end
    if (hit) begin
      rec_nxt.started   = 1'b1;
      rec_nxt.start_idx = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec_r <= rec_nxt;
    end
  end

  assign vld_out = vld_r;
  assign rec_out = rec_r;

endmodule

`default_nettype wire

// File: sv/i2a_ser.sv
// ----------------------------------------------------------------------------
// i2a_ser
// Character serialiser: holds one converted number and sends its text one
// character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_hex_decimal_top_macros.svh"

module i2a_ser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ld_vld,
  input  wire i2a_pkg::conv_rec_t ld_rec,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [6:0]              out_character,
  output logic                    out_last
);

  logic               busy_r, busy_nxt;
  logic [3:0]         pos_r, pos_nxt;
  i2a_pkg::conv_rec_t rec_r, rec_nxt;
  logic [3:0]         len;
  logic [3:0]         didx;
  logic [3:0]         digit;
  logic               last;
  logic               fire;

  always_comb begin
    unique case (rec_r.mode)
      i2a_pkg::MODE_HEX_BYTE: len = 4'd2;
      i2a_pkg::MODE_HEX_WORD: len = 4'd8;
      i2a_pkg::MODE_UDEC:     len = 4'd10 - rec_r.start_idx;
      i2a_pkg::MODE_SDEC:     len = 4'd11 - rec_r.start_idx;
      default:                len = 4'd1;
    endcase
  end

  assign last = (pos_r == len - 4'd1);
  assign fire = busy_r && !out_stall;
  assign free = !busy_r || (fire && last);

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    rec_nxt  = rec_r;
    if (free) begin
      busy_nxt = ld_vld;
      pos_nxt  = 4'd0;
      rec_nxt  = ld_rec;
    end else if (fire) begin
      pos_nxt = pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  // In signed mode the first character is the sign, so digits lag by one.
  always_comb begin
    didx = rec_r.start_idx + pos_r
         - ((rec_r.mode == i2a_pkg::MODE_SDEC) ? 4'd1 : 4'd0);
    digit = (didx <= i2a_pkg::LAST_DIGIT) ? rec_r.digits[didx] : 4'd0;
  end

  always_comb begin
    unique case (rec_r.mode)
      i2a_pkg::MODE_HEX_BYTE:
        out_character = i2a_pkg::hex_char(pos_r[0] ? rec_r.num[3:0] : rec_r.num[7:4]);
      i2a_pkg::MODE_HEX_WORD:
        out_character = i2a_pkg::hex_char(rec_r.num[{~pos_r[2:0], 2'b00} +: 4]);
      i2a_pkg::MODE_UDEC:
        out_character = i2a_pkg::dec_char(digit);
      i2a_pkg::MODE_SDEC: begin
        if (pos_r == 4'd0) begin
          out_character = rec_r.neg ? i2a_pkg::CHAR_MINUS : i2a_pkg::CHAR_SPACE;
        end else begin
          out_character = i2a_pkg::dec_char(digit);
        end
      end
      default: out_character = i2a_pkg::CHAR_SPACE;
    endcase
  end

  assign out_valid = busy_r;
  assign out_last  = last;

  `I2A_ASSERT(a_hold_on_stall, (busy_r && out_stall) |=> (busy_r && $stable(pos_r)), "character position moved while stalled")
  `I2A_ASSERT(a_pos_in_text, busy_r |-> (pos_r < len), "character position beyond the end of the text")
  `I2A_ASSERT(a_digit_in_range, (busy_r && rec_r.mode[1] && !(rec_r.mode == i2a_pkg::MODE_SDEC && pos_r == 4'd0)) |-> (didx <= i2a_pkg::LAST_DIGIT), "decimal digit index out of range")
  `I2A_ASSERT_ALWAYS(a_idle_in_reset, (!rst_n) |=> !busy_r, "serialiser busy after reset")

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_hex_decimal_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_hex_decimal_top
// Converts a 32-bit value to ASCII hex or decimal text, one character a beat.
// ----------------------------------------------------------------------------
// Each input beat carries a 32-bit number and a mode: 0 gives two upper-case
// hex digits of the low byte, 1 gives eight hex digits, 2 gives unsigned
// decimal without leading zeros and 3 gives signed decimal led by '-' or a
// space (zero prints as "0" or " 0"). Every output beat carries one character,
// and out_last marks the final character of a number. The output runs at one
// character per cycle while out_stall is low; a number has 2 characters in
// mode 0, 8 in mode 1, 1 to 10 in mode 2 and 2 to 11 in mode 3. A number
// waiting in the last cell follows the one before with no gap on the output.
// The decimal digits are produced by a row of ten digit cells, one per power
// of ten, behind a register that takes the magnitude; an input beat passes
// through that register, the cells and the serialiser register before its
// first character appears. Input beats are taken every cycle while the row
// has room; the row stalls as a whole only when its last cell holds a number
// that the serialiser cannot yet take.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_hex_decimal_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_character,
  output logic             out_last
);

  logic                       en;
  logic                       ser_free;
  logic                       prep_vld_r;
  i2a_pkg::conv_rec_t         prep_rec_r;
  i2a_pkg::conv_rec_t         prep_rec_nxt;
  logic [i2a_pkg::NUM_DIGITS:0] chain_vld;
  i2a_pkg::conv_rec_t         chain_rec [i2a_pkg::NUM_DIGITS+1];

  // The whole row moves together whenever the last cell is empty or its
  // number is being handed to the serialiser in this cycle.
  assign en       = !chain_vld[i2a_pkg::NUM_DIGITS] || ser_free;
  assign in_stall = !en;

  // Front register: the sign is settled here and the magnitude is taken,
  // so the most negative value enters the cells as its unsigned magnitude.
  always_comb begin
    prep_rec_nxt.mode      = i2a_pkg::mode_t'(in_mode);
    prep_rec_nxt.neg       = (in_mode == i2a_pkg::MODE_SDEC) && in_number[31];
    prep_rec_nxt.num       = in_number;
    prep_rec_nxt.rem       = prep_rec_nxt.neg ? (32'd0 - in_number) : in_number;
    prep_rec_nxt.digits    = '0;
    prep_rec_nxt.started   = 1'b0;
    prep_rec_nxt.start_idx = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_rec_r <= prep_rec_nxt;
    end
  end

  assign chain_vld[0] = prep_vld_r;
  assign chain_rec[0] = prep_rec_r;

  // Cell g works out the digit of weight ten to the power (9 - g).
  for (genvar g = 0; g < i2a_pkg::NUM_DIGITS; g++) begin : g_cell
    i2a_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (4'(g)),
      .en      (en),
      .vld_in  (chain_vld[g]),
      .rec_in  (chain_rec[g]),
      .vld_out (chain_vld[g+1]),
      .rec_out (chain_rec[g+1])
    );
  end

  i2a_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld_vld        (chain_vld[i2a_pkg::NUM_DIGITS]),
    .ld_rec        (chain_rec[i2a_pkg::NUM_DIGITS]),
    .free          (ser_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer to ASCII hex and decimal converter.
// ----------------------------------------------------------------------------
// Numbers are sent in all four modes, with both sides idling and stalling at
// random. Every accepted number is turned into the text it should produce.
// Each output beat is then checked, code and last flag, against the oldest
// character still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          RANDOM_ITEMS = 500;

  // One character of expected text.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } ascii_char_t;

  // Holds the characters that accepted numbers still owe. Each accepted number
  // is converted here, and each output beat is compared with the oldest
  // character in the queue.
  class ascii_text_board;
    ascii_char_t pending_chars[$];
    int          errors;
    int unsigned beats_seen;

    function new();
      errors     = 0;
      beats_seen = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    // Prints one line for the mismatch and counts it.
    task report_mismatch(input string msg);
      $display("MISMATCH at beat %0d: %s", beats_seen, msg);
      errors++;
    endtask

    function void push_code(input logic [6:0] code);
      ascii_char_t c;
      c.code = code;
      c.last = 1'b0;
      pending_chars.push_back(c);
    endfunction

    function void push_hex(input logic [3:0] nibble);
      if (nibble <= 4'd9) begin
        push_code(i2a_pkg::CHAR_ZERO + 7'(nibble));
      end else begin
        push_code(i2a_pkg::CHAR_UPPER_A + 7'(nibble - 4'd10));
      end
    endfunction

    // Decimal digits of mag, leading zeros dropped, but the units digit is
    // always printed, so zero comes out as a single "0".
    function void push_decimal(input logic [31:0] mag);
      logic [31:0] weight;
      logic [31:0] digit;
      bit          started;
      weight  = 32'd1000000000;
      started = 1'b0;
      for (int i = 0; i < 10; i++) begin
        digit = mag / weight;
        mag   = mag % weight;
        if (digit != 0 || started || weight == 32'd1) begin
          started = 1'b1;
          push_code(i2a_pkg::CHAR_ZERO + 7'(digit));
        end
        weight = weight / 10;
      end
    endfunction

    // Works out the text of one accepted number and queues it.
    function void note_number(input i2a_pkg::mode_t mode, input logic [31:0] number);
      ascii_char_t tail;
      case (mode)
        i2a_pkg::MODE_HEX_BYTE: begin
          push_hex(number[7:4]);
          push_hex(number[3:0]);
        end
        i2a_pkg::MODE_HEX_WORD: begin
          for (int s = 28; s >= 0; s -= 4) begin
            push_hex(4'(number >> s));
          end
        end
        i2a_pkg::MODE_UDEC: begin
          push_decimal(number);
        end
        default: begin
          // The magnitude of the most negative value wraps back to itself,
          // which read as unsigned is exactly 2147483648.
          if (number[31]) begin
            push_code(i2a_pkg::CHAR_MINUS);
            push_decimal(~number + 32'd1);
          end else begin
            push_code(i2a_pkg::CHAR_SPACE);
            push_decimal(number);
          end
        end
      endcase
      tail      = pending_chars.pop_back();
      tail.last = 1'b1;
      pending_chars.push_back(tail);
    endfunction

    task check_char(input logic [6:0] code, input logic last);
      ascii_char_t want;
      beats_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h arrived with nothing owed", code));
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        report_mismatch($sformatf("character 0x%02h, wanted 0x%02h", code, want.code));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last flag %b, wanted %b", last, want.last));
      end
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode   = 2'd0;
  logic [31:0] in_number = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_character;
  logic        out_last;

  ascii_text_board text_board = new();

  // Switches for the idling on each side, and the request for one long
  // hold-off on the output, which the receiving process counts out itself.
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned cycle_count = 0;

  integer_to_ascii_hex_decimal_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Runaway guard: well beyond the slowest correct run, in which every
  // character would wait out the longest random stall.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random numbers, weighted towards the awkward corners of the decimal path:
  // small values, values around powers of ten, short bit lengths, small
  // negatives and the neighbourhood of the most negative value.
  function automatic logic [31:0] rand_number();
    logic [31:0] p;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 32'd1;
      end
      3: return $urandom >> $urandom_range(0, 31);
      4: return 32'd0 - $urandom_range(1, 20);
      default: return 32'h8000_0000 ^ $urandom_range(0, 3);
    endcase
  endfunction

  // Receiving side. Each beat taken at an edge is checked, and the stall for
  // the next cycle is then chosen. Random stall runs never join up, so but for
  // the long hold-off a character never waits longer than one run.
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        text_board.check_char(out_character, out_last);
      end
      if (hold_req) begin
        stall_run = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (stall_run == 0 && !out_stall && stalls_on &&
                   $urandom_range(0, 3) == 0) begin
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one number and waits for the beat to be taken, then idles for a
  // random while. Valid is only lowered when a gap follows, so it is never
  // dropped and raised again in the same step.
  task automatic send_number(input i2a_pkg::mode_t mode, input logic [31:0] number);
    int gap;
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_number <= number;
    do @(posedge clk); while (in_stall !== 1'b0);
    text_board.note_number(mode, number);
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (text_board.pending() != 0);
  endtask

  initial begin
    // Synchronous reset, held while the clock runs and then released.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed numbers: the ends of every mode, digits on both sides of the
    // hex letter boundary, bits above the low byte that must be ignored,
    // zero in both decimal modes, powers of ten and the most negative value.
    send_number(i2a_pkg::MODE_HEX_BYTE, 32'h0000_0000);
    send_number(i2a_pkg::MODE_HEX_BYTE, 32'h0000_00FF);
    send_number(i2a_pkg::MODE_HEX_BYTE, 32'hFFFF_FF9A);
    send_number(i2a_pkg::MODE_HEX_WORD, 32'h0000_0000);
    send_number(i2a_pkg::MODE_HEX_WORD, 32'hFFFF_FFFF);
    send_number(i2a_pkg::MODE_HEX_WORD, 32'h0123_89AB);
    send_number(i2a_pkg::MODE_HEX_WORD, 32'hCDEF_4567);
    send_number(i2a_pkg::MODE_UDEC,     32'd0);
    send_number(i2a_pkg::MODE_UDEC,     32'd9);
    send_number(i2a_pkg::MODE_UDEC,     32'd10);
    send_number(i2a_pkg::MODE_UDEC,     32'd255);
    send_number(i2a_pkg::MODE_UDEC,     32'd999999999);
    send_number(i2a_pkg::MODE_UDEC,     32'd1000000000);
    send_number(i2a_pkg::MODE_UDEC,     32'd4000000007);
    send_number(i2a_pkg::MODE_UDEC,     32'hFFFF_FFFF);
    send_number(i2a_pkg::MODE_SDEC,     32'd0);
    send_number(i2a_pkg::MODE_SDEC,     32'd1);
    send_number(i2a_pkg::MODE_SDEC,     32'hFFFF_FFFF);
    send_number(i2a_pkg::MODE_SDEC,     32'd0 - 32'd10);
    send_number(i2a_pkg::MODE_SDEC,     32'h7FFF_FFFF);
    send_number(i2a_pkg::MODE_SDEC,     32'h8000_0000);
    send_number(i2a_pkg::MODE_SDEC,     32'h8000_0001);
    send_number(i2a_pkg::MODE_SDEC,     32'd1000000000);

    // The sender pauses here until all of the directed text has come out.
    wait_drained();

    // Random numbers in five blocks. The second runs at full rate on both
    // sides. In the third the receiver holds off for a long stretch while the
    // sender keeps offering back to back, so the converter fills up and
    // stalls its input.
    for (int blk = 0; blk < 5; blk++) begin
      gaps_on   = (blk != 1 && blk != 2);
      stalls_on = (blk != 1);
      if (blk == 2) begin
        hold_req = 1'b1;
      end
      repeat (RANDOM_ITEMS / 5) begin
        send_number(i2a_pkg::mode_t'($urandom_range(0, 3)), rand_number());
      end
      if (blk == 3) begin
        wait_drained();
      end
    end

    // Wind down: let everything owed arrive, then watch a little longer for
    // any stray beats.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_board.errors == 0 && text_board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
